[sv/md5bc_pkg.sv]
// ----------------------------------------------------------------------------
// md5bc_pkg
// Shared types, constants and round tables for the MD5 compression engine.
// ----------------------------------------------------------------------------
package md5bc_pkg;

	// Input word: command bit and one little-endian message word
	typedef struct packed {
		logic        cmd;
		logic [31:0] msg_word;
	} in_t;

	// Result word: the four chaining words after a block
	typedef struct packed {
		logic [31:0] digest_a;
		logic [31:0] digest_b;
		logic [31:0] digest_c;
		logic [31:0] digest_d;
	} out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       restart;   // return chaining words to initial values
		logic       wr_word;   // store a message word
		logic [3:0] wr_idx;    // block position of that word
		logic       load;      // copy chaining words into the working set
		logic       round_en;  // run one round
		logic [5:0] rnd;       // round index
		logic       finish;    // fold working set into chaining words
	} dp_cmd_t;

	localparam logic       CMD_START = 1'b0;
	localparam logic       CMD_WORD  = 1'b1;
	localparam logic [3:0] LAST_WORD = 4'd15;
	localparam logic [5:0] LAST_RND  = 6'd63;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	// Additive round constants (integer part of |sin(i+1)| * 2^32)
	function automatic logic [31:0] sine_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Left-rotate amount per round
	function automatic logic [4:0] shift_s(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'b0000: s = 5'd7;  4'b0001: s = 5'd12; 4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
			4'b0100: s = 5'd5;  4'b0101: s = 5'd9;  4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
			4'b1000: s = 5'd4;  4'b1001: s = 5'd11; 4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
			4'b1100: s = 5'd6;  4'b1101: s = 5'd10; 4'b1110: s = 5'd15; 4'b1111: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// Message word picked by each round
	function automatic logic [3:0] word_sel(input logic [5:0] r);
		logic [3:0] rl;
		logic [3:0] sel;
		rl = r[3:0];
		case (r[5:4])
			2'd0:    sel = rl;
			2'd1:    sel = (rl * 4'd5) + 4'd1;
			2'd2:    sel = (rl * 4'd3) + 4'd5;
			default: sel = rl * 4'd7;
		endcase
		return sel;
	endfunction

	// Nonlinear round function F, G, H or I
	function automatic logic [31:0] mix_fn(input logic [5:0] r, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] m;
		case (r[5:4])
			2'd0:    m = (b & c) | (~b & d);
			2'd1:    m = (b & d) | (c & ~d);
			2'd2:    m = b ^ c ^ d;
			default: m = c ^ (b | ~d);
		endcase
		return m;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] dbl;
		dbl = {v, v} << s;
		return dbl[63:32];
	endfunction

endpackage

[sv/md5bc_ctrl.sv]
// ----------------------------------------------------------------------------
// md5bc_ctrl
// Sequencer: counts message words, runs the 64 rounds, owns the result valid.
// ----------------------------------------------------------------------------
module md5bc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output md5bc_pkg::dp_cmd_t  dp_cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOAD   = 2'd1;
	localparam logic [1:0] ST_ROUND  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [3:0] cnt_q;
	logic [5:0] rnd_q;
	logic       out_valid_q;
	logic       in_acc;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Decode commands for the datapath
	always_comb begin
		dp_cmd          = '0;
		dp_cmd.restart  = in_acc && (in_cmd == md5bc_pkg::CMD_START);
		dp_cmd.wr_word  = in_acc && (in_cmd == md5bc_pkg::CMD_WORD);
		dp_cmd.wr_idx   = cnt_q;
		dp_cmd.load     = (state_q == ST_LOAD);
		dp_cmd.round_en = (state_q == ST_ROUND);
		dp_cmd.rnd      = rnd_q;
		dp_cmd.finish   = (state_q == ST_FINISH) && slot_free;
	end

	// Advance word count, round counter and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rnd_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_cmd == md5bc_pkg::CMD_START) begin
							cnt_q <= '0;
						end else begin
							cnt_q <= cnt_q + 4'd1;
							if (cnt_q == md5bc_pkg::LAST_WORD) begin
								state_q <= ST_LOAD;
							end
						end
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == md5bc_pkg::LAST_RND) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result valid until the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_last_word_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_cmd == md5bc_pkg::CMD_WORD && cnt_q == md5bc_pkg::LAST_WORD)
		|=> (state_q == ST_LOAD))
		else $error("sixteenth word did not start compression");
	a_start_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_cmd == md5bc_pkg::CMD_START) |=> (cnt_q == 4'd0))
		else $error("start command left word count nonzero");
	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == md5bc_pkg::LAST_RND) |=> (state_q == ST_FINISH))
		else $error("round sequence did not end after the last round");
	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !slot_free) |=> (state_q == ST_FINISH && out_valid_q))
		else $error("result overwritten while still pending");
`endif

endmodule

[sv/md5bc_datapath.sv]
// ----------------------------------------------------------------------------
// md5bc_datapath
// Block buffer, chaining words, working registers and the round unit.
// ----------------------------------------------------------------------------
module md5bc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         msg_word,
	input  md5bc_pkg::dp_cmd_t  dp_cmd,
	output md5bc_pkg::out_t     digest
);

	logic [31:0] block_words [16];
	logic [31:0] chain_a_q, chain_b_q, chain_c_q, chain_d_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] pre_q;
	md5bc_pkg::out_t digest_q;

	logic [5:0]  next_rnd;
	logic [31:0] pre_base;
	logic [31:0] pre_next;
	logic [31:0] round_sum;
	logic [31:0] b_next;

	// Store message words
	always_ff @(posedge clk) begin
		if (dp_cmd.wr_word) begin
			block_words[dp_cmd.wr_idx] <= msg_word;
		end
	end

	// Precompute a + K + M for the following round
	assign next_rnd = dp_cmd.load ? 6'd0 : dp_cmd.rnd + 6'd1;
	assign pre_base = dp_cmd.load ? chain_a_q : d_q;
	assign pre_next = pre_base + md5bc_pkg::sine_k(next_rnd)
		+ block_words[md5bc_pkg::word_sel(next_rnd)];

	// One MD5 round
	assign round_sum = md5bc_pkg::mix_fn(dp_cmd.rnd, b_q, c_q, d_q) + pre_q;
	assign b_next    = b_q + md5bc_pkg::rotl32(round_sum, md5bc_pkg::shift_s(dp_cmd.rnd));

	// Advance the working set
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			a_q   <= chain_a_q;
			b_q   <= chain_b_q;
			c_q   <= chain_c_q;
			d_q   <= chain_d_q;
			pre_q <= pre_next;
		end else if (dp_cmd.round_en) begin
			a_q   <= d_q;
			b_q   <= b_next;
			c_q   <= b_q;
			d_q   <= c_q;
			pre_q <= pre_next;
		end
	end

	// Chaining words: restart or fold in the finished block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_a_q <= md5bc_pkg::INIT_A;
			chain_b_q <= md5bc_pkg::INIT_B;
			chain_c_q <= md5bc_pkg::INIT_C;
			chain_d_q <= md5bc_pkg::INIT_D;
		end else if (dp_cmd.restart) begin
			chain_a_q <= md5bc_pkg::INIT_A;
			chain_b_q <= md5bc_pkg::INIT_B;
			chain_c_q <= md5bc_pkg::INIT_C;
			chain_d_q <= md5bc_pkg::INIT_D;
		end else if (dp_cmd.finish) begin
			chain_a_q <= chain_a_q + a_q;
			chain_b_q <= chain_b_q + b_q;
			chain_c_q <= chain_c_q + c_q;
			chain_d_q <= chain_d_q + d_q;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (dp_cmd.finish) begin
			digest_q.digest_a <= chain_a_q + a_q;
			digest_q.digest_b <= chain_b_q + b_q;
			digest_q.digest_c <= chain_c_q + c_q;
			digest_q.digest_d <= chain_d_q + d_q;
		end
	end

	assign digest = digest_q;

endmodule

[sv/md5_block_compress.sv]
// ----------------------------------------------------------------------------
// md5_block_compress
// MD5 compression engine: collects 16 message words, runs 64 rounds.
// ----------------------------------------------------------------------------
// Each accepted word is stored in a 16-entry block buffer; a start word
// (cmd 0) returns the chaining words to the MD5 initial values and drops
// any partial block. The sixteenth word launches the compression: a load
// step, the 64 rounds of the single round unit (one round per cycle) and a
// finish step that adds the result into the chaining words. The input is
// not ready while the rounds run. The digest sits in an output register,
// so word collection for the next block goes on while it waits; the
// finish step stalls only if the previous digest is still untaken.
// Reset loads the MD5 initial chaining words, as a start word does.
// ----------------------------------------------------------------------------
module md5_block_compress (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  md5bc_pkg::in_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output md5bc_pkg::out_t  out_data
);

	md5bc_pkg::dp_cmd_t dp_cmd;

	md5bc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_cmd    (in_data.cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_cmd    (dp_cmd)
	);

	md5bc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_word (in_data.msg_word),
		.dp_cmd   (dp_cmd),
		.digest   (out_data)
	);

endmodule
